@@ rtl/core/pdof_pkg.sv @@
package pdof_pkg;

  localparam int ID_W      = 5;
  localparam int APP_W     = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int REG_IDX_W = 2;
  localparam int NUM_REGS  = 4;

  localparam logic [ID_W-1:0] MAX_SENSOR_ID = 5'd27;
  localparam logic [ID_W-1:0] ID_DISABLED   = 5'd31;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK = 2'd2;

  typedef struct packed {
    logic [APP_W-1:0]  app_id;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic            slot_found;
    logic            frame_valid;
    logic [ID_W-1:0] phys_id;
    logic            startup_needed;
  } info_t;

endpackage

@@ rtl/core/per_id_drop_oldest_frame_fifo_unit.sv @@
// Per-sensor frame queues with drop-oldest overflow. NUM_SLOTS ring queues of
// QUEUE_DEPTH frames share one frame RAM; each slot is bound to a sensor ID
// through cfg registers 0..3 (ID above 27 disables the slot, lowest slot wins
// on duplicates). Push appends and overwrites the oldest frame when full, pop
// returns the oldest frame, mark records the startup frame as sent. Each word
// taken in yields one result word, after the registered RAM read and the
// output register. A new word is taken every cycle as long as the output side
// does not stall.
module per_id_drop_oldest_frame_fifo_unit #(
  parameter int NUM_SLOTS   = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pdof_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [pdof_pkg::ID_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pdof_pkg::OP_W-1:0]          op,
  input  logic [pdof_pkg::ID_W-1:0]          phys_id,
  input  logic [pdof_pkg::APP_W-1:0]         app_id,
  input  logic [pdof_pkg::DATA_W-1:0]        frame_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               slot_found,
  output logic                               frame_valid,
  output logic [pdof_pkg::ID_W-1:0]          out_phys_id,
  output logic [pdof_pkg::APP_W-1:0]         out_app_id,
  output logic [pdof_pkg::DATA_W-1:0]        out_data,
  output logic                               startup_needed
);
  import pdof_pkg::*;

  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_SLOTS * QUEUE_DEPTH;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  logic [ID_W-1:0]  slot_id [NUM_SLOTS];
  logic [PTR_W-1:0] wptr    [NUM_SLOTS];
  logic [PTR_W-1:0] rptr    [NUM_SLOTS];
  logic [CNT_W-1:0] fill    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] sent;

  logic              accept;
  logic              hit;
  logic [SLOT_W-1:0] sel;
  logic              full;
  logic              empty;
  logic              do_push;
  logic              do_pop;
  logic              do_mark;
  logic [PTR_W-1:0]  wptr_inc;
  logic [PTR_W-1:0]  rptr_inc;
  logic [ADDR_W-1:0] base;

  logic   pend_valid;
  info_t  pend;
  info_t  info_next;
  logic   move;
  entry_t rd_data;
  entry_t wr_data;

  assign move     = pend_valid && (!out_valid || !out_stall);
  assign in_stall = pend_valid && !move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (slot_id[s] <= MAX_SENSOR_ID && slot_id[s] == phys_id) begin
        hit = 1'b1;
        sel = SLOT_W'(s);
      end
    end
  end

  assign full     = fill[sel] == CNT_W'(QUEUE_DEPTH);
  assign empty    = fill[sel] == '0;
  assign do_push  = accept && hit && op == OP_PUSH;
  assign do_pop   = accept && hit && op == OP_POP && !empty;
  assign do_mark  = accept && hit && op == OP_MARK;
  assign wptr_inc = (wptr[sel] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr[sel] + 1'b1;
  assign rptr_inc = (rptr[sel] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr[sel] + 1'b1;
  assign base     = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH);
  assign wr_data  = '{app_id: app_id, data: frame_data};

  always_comb begin
    info_next.slot_found     = hit;
    info_next.frame_valid    = hit && op == OP_POP && !empty;
    info_next.phys_id        = phys_id;
    info_next.startup_needed = hit && !sent[sel] && op != OP_MARK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_id[s] <= ID_DISABLED;
        wptr[s]    <= '0;
        rptr[s]    <= '0;
        fill[s]    <= '0;
      end
      sent <= '0;
    end else begin
      if (cfg_write) begin
        for (int s = 0; s < NUM_SLOTS && s < NUM_REGS; s++) begin
          if (int'(cfg_index) == s) begin
            slot_id[s] <= cfg_data;
          end
        end
      end
      if (do_push) begin
        wptr[sel] <= wptr_inc;
        if (full) begin
          rptr[sel] <= rptr_inc;
        end else begin
          fill[sel] <= fill[sel] + 1'b1;
        end
      end
      if (do_pop) begin
        rptr[sel] <= rptr_inc;
        fill[sel] <= fill[sel] - 1'b1;
      end
      if (do_mark) begin
        sent[sel] <= 1'b1;
      end
    end
  end

  pdof_frame_ram #(
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (base + ADDR_W'(wptr[sel])),
    .wr_data (wr_data),
    .rd_en   (do_pop),
    .rd_addr (base + ADDR_W'(rptr[sel])),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= info_next;
    end
    if (move) begin
      slot_found     <= pend.slot_found;
      frame_valid    <= pend.frame_valid;
      out_phys_id    <= pend.phys_id;
      startup_needed <= pend.startup_needed;
      out_app_id     <= pend.frame_valid ? rd_data.app_id : '0;
      out_data       <= pend.frame_valid ? rd_data.data : '0;
    end
  end

  a_valid_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_valid |-> slot_found)
    else $error("frame returned without a matching slot");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |-> out_app_id == '0 && out_data == '0)
    else $error("nonzero payload on result without frame");

  a_need_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !slot_found |-> !startup_needed)
    else $error("startup flag reported without a slot");

  a_pop_reads_nonempty: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> fill[sel] != '0)
    else $error("pop issued on empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    accept && hit |-> fill[sel] <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

endmodule

@@ rtl/core/pdof_frame_ram.sv @@
module pdof_frame_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  pdof_pkg::entry_t    wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pdof_pkg::entry_t    rd_data
);
  import pdof_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdof_pkg::*;

  localparam int NSLOTS = 4;
  localparam int QDEPTH = 8;
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   kind;
    logic [ID_W-1:0]   id;
    logic [APP_W-1:0]  app;
    logic [DATA_W-1:0] data;
  } frame_req_t;

  typedef struct packed {
    logic              found;
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [APP_W-1:0]  app;
    logic [DATA_W-1:0] data;
    logic              need;
  } frame_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [ID_W-1:0]     cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op = OP_PUSH;
  logic [ID_W-1:0]     phys_id = '0;
  logic [APP_W-1:0]    app_id = '0;
  logic [DATA_W-1:0]   frame_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                slot_found;
  logic                frame_valid;
  logic [ID_W-1:0]     out_phys_id;
  logic [APP_W-1:0]    out_app_id;
  logic [DATA_W-1:0]   out_data;
  logic                startup_needed;

  per_id_drop_oldest_frame_fifo_unit #(
    .NUM_SLOTS  (NSLOTS),
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .phys_id       (phys_id),
    .app_id        (app_id),
    .frame_data    (frame_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_found    (slot_found),
    .frame_valid   (frame_valid),
    .out_phys_id   (out_phys_id),
    .out_app_id    (out_app_id),
    .out_data      (out_data),
    .startup_needed(startup_needed)
  );

  always #5 clk = ~clk;

  // slot queue model
  logic [ID_W-1:0]  bind_id [NSLOTS];
  entry_t           ring [NSLOTS][QDEPTH];
  logic [PTR_W-1:0] wr_ptr [NSLOTS];
  logic [PTR_W-1:0] rd_ptr [NSLOTS];
  logic [PTR_W:0]   fill [NSLOTS];
  logic             sent [NSLOTS];

  frame_req_t    pending_reqs[$];
  frame_result_t due_results[$];
  int            errors = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            idle_cycles = 0;
  bit            quiet = 1'b0;

  function automatic frame_result_t apply_frame_op(logic [OP_W-1:0] kind, logic [ID_W-1:0] id,
                                                   logic [APP_W-1:0] app,
                                                   logic [DATA_W-1:0] data);
    frame_result_t r;
    int hit;
    r = '0;
    r.id = id;
    hit = -1;
    for (int s = NSLOTS - 1; s >= 0; s--)
      if (bind_id[s] <= MAX_SENSOR_ID && bind_id[s] == id) hit = s;
    if (hit >= 0) begin
      r.found = 1'b1;
      case (kind)
        OP_PUSH: begin
          if (fill[hit] == QDEPTH) begin
            rd_ptr[hit]++;
            fill[hit]--;
          end
          ring[hit][wr_ptr[hit]].app_id = app;
          ring[hit][wr_ptr[hit]].data = data;
          wr_ptr[hit]++;
          fill[hit]++;
        end
        OP_POP: begin
          if (fill[hit] != 0) begin
            r.valid = 1'b1;
            r.app = ring[hit][rd_ptr[hit]].app_id;
            r.data = ring[hit][rd_ptr[hit]].data;
            rd_ptr[hit]++;
            fill[hit]--;
          end
        end
        OP_MARK: sent[hit] = 1'b1;
        default: ;
      endcase
      r.need = !sent[hit];
    end
    return r;
  endfunction

  function automatic int pick_idle();
    int r;
    if ($urandom_range(0, 299) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(logic [OP_W-1:0] kind, logic [ID_W-1:0] id, logic [APP_W-1:0] app,
                         logic [DATA_W-1:0] data);
    frame_req_t q;
    q.kind = kind;
    q.id = id;
    q.app = app;
    q.data = data;
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bindings(logic [ID_W-1:0] a, logic [ID_W-1:0] b, logic [ID_W-1:0] c,
                              logic [ID_W-1:0] d);
    logic [ID_W-1:0] v [NSLOTS];
    v = '{a, b, c, d};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data <= v[i];
      bind_id[i] = v[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // word driver
  always @(posedge clk) begin
    frame_req_t q;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        due_results.push_back(apply_frame_op(op, phys_id, app_id, frame_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          q = pending_reqs.pop_front();
          op <= q.kind;
          phys_id <= q.id;
          app_id <= q.app;
          frame_data <= q.data;
          in_valid <= 1'b1;
          gap_left = pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, got id %h", $time,
                   out_phys_id);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("slot_found", 32'(want.found), 32'(slot_found));
          check_field("frame_valid", 32'(want.valid), 32'(frame_valid));
          check_field("out_phys_id", 32'(want.id), 32'(out_phys_id));
          check_field("out_app_id", 32'(want.app), 32'(out_app_id));
          check_field("out_data", want.data, out_data);
          check_field("startup_needed", 32'(want.need), 32'(startup_needed));
        end
      end
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_idle();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int push_pct;
    int r;
    logic [OP_W-1:0]   kind;
    logic [ID_W-1:0]   id;
    logic [APP_W-1:0]  app;
    logic [DATA_W-1:0] data;

    for (int s = 0; s < NSLOTS; s++) begin
      bind_id[s] = ID_DISABLED;
      wr_ptr[s] = '0;
      rd_ptr[s] = '0;
      fill[s] = '0;
      sent[s] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all slots disabled after reset
    add_req(OP_PUSH, 5'd0, 16'hffff, 32'hffffffff);
    add_req(OP_POP, 5'd31, 16'h0, 32'h0);
    add_req(OP_MARK, 5'd5, 16'h1234, 32'h0);
    drain();

    // duplicate ID on slots 2 and 3, extremes 0 and 27 bound
    set_bindings(5'd0, MAX_SENSOR_ID, 5'd5, 5'd5);
    add_req(OP_POP, 5'd0, 16'hffff, 32'hffffffff);
    add_req(OP_NONE, MAX_SENSOR_ID, 16'h0, 32'h0);
    add_req(OP_PUSH, 5'd0, 16'h0, 32'h0);
    add_req(OP_PUSH, 5'd0, 16'hffff, 32'hffffffff);
    add_req(OP_POP, 5'd0, 16'h0, 32'h0);
    add_req(OP_POP, 5'd0, 16'h0, 32'h0);
    for (int i = 0; i < QDEPTH + 1; i++)
      add_req(OP_PUSH, MAX_SENSOR_ID, 16'(i + 16'h100), 32'(i) ^ 32'ha5a5_0000);
    add_req(OP_POP, MAX_SENSOR_ID, 16'h0, 32'h0);
    add_req(OP_MARK, 5'd5, 16'h0, 32'h0);
    add_req(OP_PUSH, 5'd5, 16'h5555, 32'h5555_aaaa);
    add_req(OP_POP, 5'd5, 16'h0, 32'h0);
    add_req(OP_PUSH, 5'd31, 16'hffff, 32'hffffffff);
    add_req(OP_MARK, 5'd0, 16'h0, 32'h0);
    add_req(OP_NONE, 5'd0, 16'hffff, 32'hffffffff);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_bindings(5'd3, 5'd9, 5'd17, 5'd24);
        1: set_bindings(5'd0, 5'd0, 5'd0, 5'd0);
        2: set_bindings(MAX_SENSOR_ID, 5'd28, MAX_SENSOR_ID, ID_DISABLED);
        3: set_bindings(5'd28, 5'd29, 5'd30, ID_DISABLED);
        default: set_bindings(ID_W'($urandom_range(0, 31)), ID_W'($urandom_range(0, 31)),
                              ID_W'($urandom_range(0, 31)), ID_W'($urandom_range(0, 31)));
      endcase
      push_pct = 50;
      for (int n = 0; n < 200; n++) begin
        if (n % 25 == 0) push_pct = $urandom_range(15, 85);
        if ($urandom_range(0, 99) < push_pct) begin
          kind = OP_PUSH;
        end else begin
          r = $urandom_range(0, 99);
          kind = (r < 86) ? OP_POP : (r < 93) ? OP_MARK : OP_NONE;
        end
        id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, 31))
                                          : bind_id[$urandom_range(0, NSLOTS - 1)];
        case ($urandom_range(0, 15))
          0: app = '0;
          1: app = '1;
          default: app = APP_W'($urandom);
        endcase
        case ($urandom_range(0, 15))
          0: data = '0;
          1: data = '1;
          default: data = $urandom;
        endcase
        add_req(kind, id, app, data);
      end
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ per_id_drop_oldest_frame_fifo_unit.f @@
rtl/core/pdof_pkg.sv
rtl/core/pdof_frame_ram.sv
rtl/core/per_id_drop_oldest_frame_fifo_unit.sv
test/tb.sv
